[hdl/mbbc_pkg.sv]
package mbbc_pkg;

	localparam int unsigned MAX_VERTICES_DEF = 1024;
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned INDEX_W = 10;
	localparam int unsigned POS_W = 32;
	localparam int unsigned AXES = 3;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [AXES-1:0][POS_W-1:0] vec_t;

endpackage

[hdl/mbbc_cmd_if.sv]
interface mbbc_cmd_if;

	logic                               valid;
	logic                               ready;
	logic [mbbc_pkg::ACTION_W-1:0]      action;
	logic [mbbc_pkg::INDEX_W-1:0]       vertex_index;
	logic signed [mbbc_pkg::POS_W-1:0]  pos_x;
	logic signed [mbbc_pkg::POS_W-1:0]  pos_y;
	logic signed [mbbc_pkg::POS_W-1:0]  pos_z;

	modport source (output valid, action, vertex_index, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, action, vertex_index, pos_x, pos_y, pos_z, output ready);

endinterface

[hdl/mbbc_rsp_if.sv]
interface mbbc_rsp_if;

	logic                               valid;
	logic                               ready;
	logic signed [mbbc_pkg::POS_W-1:0]  centered_x;
	logic signed [mbbc_pkg::POS_W-1:0]  centered_y;
	logic signed [mbbc_pkg::POS_W-1:0]  centered_z;
	logic                               index_error;

	modport source (output valid, centered_x, centered_y, centered_z, index_error, input ready);
	modport sink (input valid, centered_x, centered_y, centered_z, index_error, output ready);

endinterface

[hdl/mesh_bounding_box_center.sv]
// A read transaction's result passes through registered stages s1 and s2 after it is accepted.
// Throughput: one transaction of any kind per cycle while the result side takes
// results; the vertex store has one write port and one registered read port.
// Reset clears the vertex count, the bounding box and the pipeline valid flags;
// vertex store contents are undefined until written, and no clearing pass runs.
module mesh_bounding_box_center #(
	parameter int unsigned MAX_VERTICES = mbbc_pkg::MAX_VERTICES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	mbbc_cmd_if.sink        cmd,
	mbbc_rsp_if.source      rsp
);

	localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
	localparam int unsigned CMPW = (CW > mbbc_pkg::INDEX_W) ? CW : mbbc_pkg::INDEX_W;
	localparam int unsigned PW = mbbc_pkg::POS_W;
	localparam int unsigned VW = mbbc_pkg::AXES * PW;

	logic [VW-1:0]        store_mem [MAX_VERTICES];

	logic [CW-1:0]        loaded_count_q;
	mbbc_pkg::vec_t       box_min_q;
	mbbc_pkg::vec_t       box_max_q;

	logic                 valid_s1;
	logic                 error_s1;
	mbbc_pkg::vec_t       center_s1;
	logic [VW-1:0]        vertex_s1;

	logic                 valid_s2;
	logic                 error_s2;
	mbbc_pkg::vec_t       centered_s2;

	logic                 accept;
	logic                 is_load;
	logic                 is_read;
	logic                 is_clear;
	logic                 store_full;
	logic                 do_load;
	logic                 advance_s2;
	logic                 advance_s1;
	logic                 index_bad;
	logic [AW-1:0]        read_addr;
	logic [AW-1:0]        write_addr;
	mbbc_pkg::vec_t       pos_in;
	mbbc_pkg::vec_t       new_min;
	mbbc_pkg::vec_t       new_max;
	mbbc_pkg::vec_t       center_now;
	mbbc_pkg::vec_t       centered_now;

	assign advance_s2 = !valid_s2 || rsp.ready;
	assign cmd.ready  = !valid_s1 || advance_s2;
	assign advance_s1 = valid_s1 && advance_s2;
	assign accept     = cmd.valid && cmd.ready;

	assign is_load    = (cmd.action == mbbc_pkg::ACT_LOAD);
	assign is_read    = (cmd.action == mbbc_pkg::ACT_READ);
	assign is_clear   = (cmd.action == mbbc_pkg::ACT_CLEAR);
	assign store_full = (loaded_count_q == CW'(MAX_VERTICES));
	assign do_load    = accept && is_load && !store_full;

	assign index_bad  = (CMPW'(cmd.vertex_index) >= CMPW'(loaded_count_q));
	assign read_addr  = AW'(cmd.vertex_index);
	assign write_addr = AW'(loaded_count_q);
	assign pos_in     = {cmd.pos_z, cmd.pos_y, cmd.pos_x};

	always_comb begin
		logic signed [PW:0] sum;
		logic signed [PW:0] diff;
		for (int a = 0; a < mbbc_pkg::AXES; a++) begin
			if (loaded_count_q == '0) begin
				new_min[a] = pos_in[a];
				new_max[a] = pos_in[a];
			end else begin
				new_min[a] = ($signed(pos_in[a]) < $signed(box_min_q[a])) ?
					pos_in[a] : box_min_q[a];
				new_max[a] = ($signed(pos_in[a]) > $signed(box_max_q[a])) ?
					pos_in[a] : box_max_q[a];
			end
			sum = $signed({box_max_q[a][PW-1], box_max_q[a]}) +
				$signed({box_min_q[a][PW-1], box_min_q[a]});
			center_now[a] = sum[PW:1];
			diff = $signed({vertex_s1[a*PW+PW-1], vertex_s1[a*PW +: PW]}) -
				$signed({center_s1[a][PW-1], center_s1[a]});
			if (diff[PW] != diff[PW-1]) begin
				centered_now[a] = diff[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
			end else begin
				centered_now[a] = diff[PW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			store_mem[write_addr] <= pos_in;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_read) begin
			vertex_s1 <= store_mem[read_addr];
			center_s1 <= center_now;
			error_s1  <= index_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_count_q <= '0;
			box_min_q      <= '0;
			box_max_q      <= '0;
		end else if (accept && is_clear) begin
			loaded_count_q <= '0;
			box_min_q      <= '0;
			box_max_q      <= '0;
		end else if (do_load) begin
			loaded_count_q <= loaded_count_q + CW'(1);
			box_min_q      <= new_min;
			box_max_q      <= new_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= accept && is_read;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			error_s2    <= error_s1;
			centered_s2 <= error_s1 ? '0 : centered_now;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.centered_x  = centered_s2[0];
	assign rsp.centered_y  = centered_s2[1];
	assign rsp.centered_z  = centered_s2[2];
	assign rsp.index_error = error_s2;

endmodule
